// ===== design/ise_pkg.sv =====
// ============================================================================
// Interval set engine package
// Shared codes, widths and the command/status structs between the controller
// and the datapath.
// ============================================================================
package ise_pkg;

    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COORD_PORT_W = 32;
    localparam int COUNT_OUT_W = 7;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t FUNC_ADD    = 2'd0;
    localparam func_t FUNC_REMOVE = 2'd1;
    localparam func_t FUNC_QUERY  = 2'd2;
    localparam func_t FUNC_NONE   = 2'd3;

    localparam status_t STATUS_DONE     = 2'd0;
    localparam status_t STATUS_CAPACITY = 2'd1;
    localparam status_t STATUS_EMPTY    = 2'd2;

    // Commands from the controller, one per phase.
    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
        logic move;
        logic write;
        logic resp;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic skip;
        logic scan_done;
        logic is_query;
        logic no_change;
        logic move_done;
        logic write_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/ise_item_if.sv =====
// ============================================================================
// Interval set engine item channel
// Valid/ready channel carrying one operation request.
// ============================================================================
interface ise_item_if;
    logic                                valid;
    logic                                ready;
    logic [ise_pkg::FUNC_W-1:0]          func;
    logic [ise_pkg::COORD_PORT_W-1:0]    range_start;
    logic [ise_pkg::COORD_PORT_W-1:0]    range_end;

    modport source (output valid, func, range_start, range_end, input ready);
    modport sink   (input valid, func, range_start, range_end, output ready);
endinterface

// ===== design/ise_result_if.sv =====
// ============================================================================
// Interval set engine result channel
// Valid/ready channel carrying one operation result.
// ============================================================================
interface ise_result_if;
    logic                                valid;
    logic                                ready;
    logic                                covered;
    logic [ise_pkg::STATUS_W-1:0]        status;
    logic [ise_pkg::COUNT_OUT_W-1:0]     interval_count;

    modport source (output valid, covered, status, interval_count, input ready);
    modport sink   (input valid, covered, status, interval_count, output ready);
endinterface

// ===== design/interval_set_engine_core.sv =====
// ============================================================================
// Interval set engine
// Sorted set of disjoint half-open intervals with add, remove and query.
// ============================================================================
// Usage:
//   item   : valid/ready channel with func, range_start and range_end. One
//            transaction is taken only while the engine is idle.
//   result : valid/ready channel with covered, status and interval_count;
//            every item gives exactly one result transaction.
// Phases per item:
//   empty range or unused func : straight to the response.
//   query                      : scan, then response.
//   add / remove               : scan, decide, tail shift, write, response; a
//                                rejected or no-op one responds after decide.
// The interval store has a single read port: the scan reads one entry per cycle
// and the tail shift moves one entry per cycle.
// The result sits in an output register; if the receiver stalls, the engine
// finishes the next item up to its response and then waits for that register.
// Reset empties the set at once; no clearing pass is needed.
// ============================================================================
module interval_set_engine_core
#(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_WIDTH   = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    ise_item_if.sink          item,
    ise_result_if.source      result
);

    ise_pkg::ctrl_cmd_t  cmd;
    ise_pkg::dp_status_t sts;

    ise_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ise_datapath
    #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_WIDTH   (COORD_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_func     (item.func),
        .in_start    (item.range_start),
        .in_end      (item.range_end),
        .cmd         (cmd),
        .sts         (sts),
        .res_ready   (result.ready),
        .res_valid   (result.valid),
        .res_covered (result.covered),
        .res_status  (result.status),
        .res_count   (result.interval_count)
    );

endmodule

// ===== design/ise_controller.sv =====
// ============================================================================
// Interval set engine controller
// Sequences scan, decide, move, write and response phases for one item.
// ============================================================================
module ise_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ise_pkg::dp_status_t sts,
    output ise_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_MOVE   = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.skip ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = sts.is_query ? ST_RESP : ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.no_change ? ST_RESP : ST_MOVE;
            end
            ST_MOVE:
            begin
                cmd.move = 1'b1;
                if (sts.move_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (sts.write_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.resp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ise_datapath.sv =====
// ============================================================================
// Interval set engine datapath
// Interval store, scan counters, splice logic and the result register.
// ============================================================================
module ise_datapath
#(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_WIDTH   = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [ise_pkg::FUNC_W-1:0]           in_func,
    input  logic [ise_pkg::COORD_PORT_W-1:0]     in_start,
    input  logic [ise_pkg::COORD_PORT_W-1:0]     in_end,
    input  ise_pkg::ctrl_cmd_t                   cmd,
    output ise_pkg::dp_status_t                  sts,
    input  logic                                 res_ready,
    output logic                                 res_valid,
    output logic                                 res_covered,
    output logic [ise_pkg::STATUS_W-1:0]         res_status,
    output logic [ise_pkg::COUNT_OUT_W-1:0]      res_count
);

    localparam int CW    = (COORD_WIDTH < ise_pkg::COORD_PORT_W) ?
                           COORD_WIDTH : ise_pkg::COORD_PORT_W;
    localparam int AW    = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

    // Interval store.
    logic [CW-1:0] mem_s [MAX_INTERVALS];
    logic [CW-1:0] mem_e [MAX_INTERVALS];

    logic [CW-1:0] rd_s_reg;
    logic [CW-1:0] rd_e_reg;
    logic          rd_vld_reg,  rd_vld_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [CW-1:0] mem_ws;
    logic [CW-1:0] mem_wd;

    // Item and control registers.
    ise_pkg::func_t   op_reg;
    logic [CW-1:0]    s_reg;
    logic [CW-1:0]    e_reg;
    ise_pkg::status_t status_reg,  status_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] ptr_reg,     ptr_next;
    logic [CNT_W-1:0] dst_reg,     dst_next;
    logic [CNT_W-1:0] mv_rem_reg,  mv_rem_next;
    logic             dir_dn_reg,  dir_dn_next;
    logic [CNT_W-1:0] i_reg,       i_next;
    logic [CNT_W-1:0] j_reg,       j_next;
    logic             got_first_reg, got_first_next;
    logic             cover_reg,   cover_next;
    logic [CW-1:0]    first_s_reg, first_s_next;
    logic [CW-1:0]    last_e_reg,  last_e_next;
    logic [1:0]       k_reg,       k_next;
    logic [1:0]       wcnt_reg,    wcnt_next;
    logic [CW-1:0]    n0s_reg, n0e_reg, n1s_reg, n1e_reg;
    logic             res_valid_reg, res_valid_next;
    logic             res_cov_reg;
    ise_pkg::status_t res_sts_reg;
    logic [CNT_W-1:0] res_cnt_reg;

    logic [CW-1:0]    in_s;
    logic [CW-1:0]    in_e;
    logic             is_add;
    logic             lo_pred;
    logic             hi_pred;

    // Decide-phase combinational results.
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] tail;
    logic [1:0]       k_c;
    logic             left_c, right_c;
    logic             reject_c, noop_c;
    logic [CW-1:0]    c0s, c0e, c1s, c1e;
    logic [CNT_W-1:0] wr_idx;

    assign in_s   = in_start[CW-1:0];
    assign in_e   = in_end[CW-1:0];
    assign is_add = (op_reg == ise_pkg::FUNC_ADD);

    // Add looks for intervals that overlap or touch; remove only for overlap.
    assign lo_pred = is_add ? (rd_e_reg < s_reg) : (rd_e_reg <= s_reg);
    assign hi_pred = is_add ? (rd_s_reg <= e_reg) : (rd_s_reg < e_reg);

    assign span   = j_reg - i_reg;
    assign tail   = count_reg - j_reg;
    assign wr_idx = i_reg + CNT_W'(wcnt_reg);

    always_comb
    begin
        left_c   = 1'b0;
        right_c  = 1'b0;
        k_c      = 2'd0;
        reject_c = 1'b0;
        noop_c   = 1'b0;
        c0s      = s_reg;
        c0e      = e_reg;
        c1s      = e_reg;
        c1e      = last_e_reg;
        if (is_add)
        begin
            k_c = 2'd1;
            if (i_reg == j_reg)
            begin
                reject_c = (count_reg >= MAX_CNT);
            end
            else
            begin
                c0s = (first_s_reg < s_reg) ? first_s_reg : s_reg;
                c0e = (last_e_reg > e_reg) ? last_e_reg : e_reg;
            end
            noop_c = reject_c;
        end
        else
        begin
            left_c  = (first_s_reg < s_reg);
            right_c = (last_e_reg > e_reg);
            k_c     = {1'b0, left_c} + {1'b0, right_c};
            if (left_c)
            begin
                c0s = first_s_reg;
                c0e = s_reg;
            end
            else
            begin
                c0s = e_reg;
                c0e = last_e_reg;
            end
            // A split of a single interval needs one extra slot.
            reject_c = (k_c == 2'd2) && (span == CNT_W'(1)) && (count_reg >= MAX_CNT);
            noop_c   = reject_c || (i_reg == j_reg);
        end
    end

    always_comb
    begin
        status_next    = status_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        dst_next       = dst_reg;
        mv_rem_next    = mv_rem_reg;
        dir_dn_next    = dir_dn_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        got_first_next = got_first_reg;
        cover_next     = cover_reg;
        first_s_next   = first_s_reg;
        last_e_next    = last_e_reg;
        k_next         = k_reg;
        wcnt_next      = wcnt_reg;
        rd_vld_next    = rd_vld_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (cmd.start)
        begin
            status_next    = ((in_func != ise_pkg::FUNC_NONE) && (in_s >= in_e)) ?
                             ise_pkg::STATUS_EMPTY : ise_pkg::STATUS_DONE;
            ptr_next       = '0;
            rd_vld_next    = 1'b0;
            i_next         = '0;
            j_next         = '0;
            got_first_next = 1'b0;
            cover_next     = 1'b0;
            wcnt_next      = '0;
        end

        if (cmd.scan)
        begin
            if (ptr_reg < count_reg)
            begin
                ptr_next    = ptr_reg + CNT_W'(1);
                rd_vld_next = 1'b1;
            end
            else
            begin
                rd_vld_next = 1'b0;
            end
            if (rd_vld_reg)
            begin
                if (lo_pred)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else if (!got_first_reg)
                begin
                    got_first_next = 1'b1;
                    first_s_next   = rd_s_reg;
                end
                if (hi_pred)
                begin
                    j_next      = j_reg + CNT_W'(1);
                    last_e_next = rd_e_reg;
                end
                if ((rd_s_reg <= s_reg) && (rd_e_reg >= e_reg))
                begin
                    cover_next = 1'b1;
                end
            end
        end

        if (cmd.decide)
        begin
            k_next = k_c;
            if (reject_c)
            begin
                status_next = ise_pkg::STATUS_CAPACITY;
            end
            if (!noop_c)
            begin
                count_next = i_reg + CNT_W'(k_c) + tail;
                // Growing shifts the tail up from the top; shrinking shifts down.
                if (CNT_W'(k_c) > span)
                begin
                    dir_dn_next = 1'b1;
                    ptr_next    = count_reg - CNT_W'(1);
                    dst_next    = count_reg;
                    mv_rem_next = tail;
                end
                else
                begin
                    dir_dn_next = 1'b0;
                    ptr_next    = j_reg;
                    dst_next    = i_reg + CNT_W'(k_c);
                    mv_rem_next = (CNT_W'(k_c) == span) ? '0 : tail;
                end
            end
            rd_vld_next = 1'b0;
        end

        if (cmd.move)
        begin
            if (mv_rem_reg != '0)
            begin
                ptr_next    = dir_dn_reg ? (ptr_reg - CNT_W'(1)) : (ptr_reg + CNT_W'(1));
                mv_rem_next = mv_rem_reg - CNT_W'(1);
                rd_vld_next = 1'b1;
            end
            else
            begin
                rd_vld_next = 1'b0;
            end
            if (rd_vld_reg)
            begin
                dst_next = dir_dn_reg ? (dst_reg - CNT_W'(1)) : (dst_reg + CNT_W'(1));
            end
        end

        if (cmd.write && (wcnt_reg != k_reg))
        begin
            wcnt_next = wcnt_reg + 2'd1;
        end

        if (cmd.resp)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = dst_reg[AW-1:0];
        mem_ws = rd_s_reg;
        mem_wd = rd_e_reg;
        if (cmd.move)
        begin
            mem_we = rd_vld_reg;
        end
        else if (cmd.write)
        begin
            mem_we = (wcnt_reg != k_reg);
            mem_wa = wr_idx[AW-1:0];
            mem_ws = (wcnt_reg == 2'd0) ? n0s_reg : n1s_reg;
            mem_wd = (wcnt_reg == 2'd0) ? n0e_reg : n1e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_s[mem_wa] <= mem_ws;
            mem_e[mem_wa] <= mem_wd;
        end
        rd_s_reg <= mem_s[ptr_reg[AW-1:0]];
        rd_e_reg <= mem_e[ptr_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= in_func;
            s_reg  <= in_s;
            e_reg  <= in_e;
        end
        if (cmd.decide)
        begin
            n0s_reg <= c0s;
            n0e_reg <= c0e;
            n1s_reg <= c1s;
            n1e_reg <= c1e;
        end
        if (cmd.resp)
        begin
            res_cov_reg <= cover_reg && (op_reg == ise_pkg::FUNC_QUERY);
            res_sts_reg <= status_reg;
            res_cnt_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ise_pkg::STATUS_DONE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            dst_reg       <= '0;
            mv_rem_reg    <= '0;
            dir_dn_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            got_first_reg <= 1'b0;
            cover_reg     <= 1'b0;
            first_s_reg   <= '0;
            last_e_reg    <= '0;
            k_reg         <= '0;
            wcnt_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            dst_reg       <= dst_next;
            mv_rem_reg    <= mv_rem_next;
            dir_dn_reg    <= dir_dn_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            got_first_reg <= got_first_next;
            cover_reg     <= cover_next;
            first_s_reg   <= first_s_next;
            last_e_reg    <= last_e_next;
            k_reg         <= k_next;
            wcnt_reg      <= wcnt_next;
            rd_vld_reg    <= rd_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign sts.skip       = (in_func == ise_pkg::FUNC_NONE) || (in_s >= in_e);
    assign sts.scan_done  = (ptr_reg == count_reg) && !rd_vld_reg;
    assign sts.is_query   = (op_reg == ise_pkg::FUNC_QUERY);
    assign sts.no_change  = noop_c;
    assign sts.move_done  = (mv_rem_reg == '0) && !rd_vld_reg;
    assign sts.write_done = (wcnt_reg == k_reg);
    assign sts.out_free   = !res_valid_reg || res_ready;

    assign res_valid   = res_valid_reg;
    assign res_covered = res_cov_reg;
    assign res_status  = res_sts_reg;
    assign res_count   = ise_pkg::COUNT_OUT_W'(res_cnt_reg);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("interval count above capacity");

    a_move_dst: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.move && rd_vld_reg) |-> (dst_reg < MAX_CNT))
        else $error("tail move writes beyond the store");

    a_new_entry_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && (wcnt_reg != k_reg)) |-> (wr_idx < MAX_CNT))
        else $error("new interval written beyond the store");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && reject_c) |=> $stable(count_reg))
        else $error("rejected operation changed the count");
`endif

endmodule

// ===== verif/interval_set_engine_core_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Interval set engine testbench
// Drives add, remove, query and unused-func transactions into the engine, predicts each
// result from a behavioral copy of the sorted interval set and compares every
// field. Both channels idle at random; one long receiver stall and three drain
// pause are included.
// ============================================================================
module interval_set_engine_core_test;

    localparam int CAP = 64;
    localparam int RANDOM_ITEMS = 355;

    typedef struct packed {
        logic                             covered;
        ise_pkg::status_t                 status;
        logic [ise_pkg::COUNT_OUT_W-1:0]  interval_count;
    } outcome_t;

    typedef struct {
        ise_pkg::func_t func;
        logic [31:0]    lo;
        logic [31:0]    hi;
        logic           known;
        outcome_t       res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ise_item_if   item();
    ise_result_if result();

    interval_set_engine_core #(.MAX_INTERVALS(CAP), .COORD_WIDTH(32)) i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.sink)
    );

    // Predicted copy of the interval set.
    logic [31:0] set_lo[$];
    logic [31:0] set_hi[$];

    outcome_t pending_results[$];
    int       error_count;
    int       accepted_count;
    int       result_count;
    int       capacity_hits;
    int       split_count;
    bit       sender_done;
    bit       rx_long_stall;
    bit       rx_no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    function automatic outcome_t predict_interval_op(input ise_pkg::func_t f,
                                                     input logic [31:0] s,
                                                     input logic [31:0] e);
        outcome_t    r;
        int          i;
        int          j;
        int          n;
        logic [31:0] ms;
        logic [31:0] me;
        logic [31:0] ins_lo[$];
        logic [31:0] ins_hi[$];
        r = '0;
        r.status = ise_pkg::STATUS_DONE;
        n = set_lo.size();
        if (f != ise_pkg::FUNC_NONE && s >= e)
        begin
            r.status = ise_pkg::STATUS_EMPTY;
        end
        else if (f == ise_pkg::FUNC_ADD)
        begin
            i = 0;
            while (i < n && set_hi[i] < s) i++;
            j = i;
            while (j < n && set_lo[j] <= e) j++;
            if (i == j && n >= CAP)
            begin
                r.status = ise_pkg::STATUS_CAPACITY;
            end
            else
            begin
                ms = s;
                me = e;
                if (i != j)
                begin
                    if (set_lo[i] < s) ms = set_lo[i];
                    if (set_hi[j-1] > e) me = set_hi[j-1];
                end
                for (int k = i; k < j; k++)
                begin
                    set_lo.delete(i);
                    set_hi.delete(i);
                end
                set_lo.insert(i, ms);
                set_hi.insert(i, me);
            end
        end
        else if (f == ise_pkg::FUNC_REMOVE)
        begin
            i = 0;
            while (i < n && set_hi[i] <= s) i++;
            j = i;
            while (j < n && set_lo[j] < e) j++;
            if (i != j)
            begin
                if (set_lo[i] < s)
                begin
                    ins_lo.push_back(set_lo[i]);
                    ins_hi.push_back(s);
                end
                if (set_hi[j-1] > e)
                begin
                    ins_lo.push_back(e);
                    ins_hi.push_back(set_hi[j-1]);
                end
                if (ins_lo.size() > j - i && n >= CAP)
                begin
                    r.status = ise_pkg::STATUS_CAPACITY;
                end
                else
                begin
                    if (ins_lo.size() > j - i) split_count++;
                    for (int k = i; k < j; k++)
                    begin
                        set_lo.delete(i);
                        set_hi.delete(i);
                    end
                    for (int k = ins_lo.size() - 1; k >= 0; k--)
                    begin
                        set_lo.insert(i, ins_lo[k]);
                        set_hi.insert(i, ins_hi[k]);
                    end
                end
            end
        end
        else if (f == ise_pkg::FUNC_QUERY)
        begin
            for (int k = 0; k < n; k++)
                if (set_lo[k] <= s && set_hi[k] >= e) r.covered = 1'b1;
        end
        if (r.status == ise_pkg::STATUS_CAPACITY) capacity_hits++;
        r.interval_count = ise_pkg::COUNT_OUT_W'(set_lo.size());
        return r;
    endfunction

    // Sender.
    task automatic send_item(input ise_pkg::func_t f, input logic [31:0] s,
                             input logic [31:0] e, input bit allow_idle);
        int gap;
        if (allow_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.func        <= f;
        item.range_start <= s;
        item.range_end   <= e;
        do @(posedge clk); while (!item.ready);
        pending_results.push_back(predict_interval_op(f, s, e));
        accepted_count++;
    endtask

    task automatic drain_results();
        item.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] small_coord();
        return $urandom_range(0, 400);
    endfunction

    stim_row_t directed[$];

    function automatic stim_row_t mk(input ise_pkg::func_t f, input logic [31:0] s,
                                     input logic [31:0] e, input bit known,
                                     input logic cov, input ise_pkg::status_t st,
                                     input int cnt);
        stim_row_t row;
        row.func = f;
        row.lo = s;
        row.hi = e;
        row.known = known;
        row.res.covered = cov;
        row.res.status = st;
        row.res.interval_count = ise_pkg::COUNT_OUT_W'(cnt);
        return row;
    endfunction

    initial
    begin
        logic [31:0]    s;
        logic [31:0]    e;
        ise_pkg::func_t f;
        int             r;
        item.valid       <= 1'b0;
        item.func        <= ise_pkg::FUNC_ADD;
        item.range_start <= '0;
        item.range_end   <= '0;
        rst_n = 1'b0;
        sender_done = 1'b0;
        rx_long_stall = 1'b0;
        rx_no_idle = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(mk(ise_pkg::FUNC_QUERY, 0, 1, 1, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_REMOVE, 0, 32'hFFFF_FFFF, 1, 0,
                              ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_ADD, 5, 5, 1, 0, ise_pkg::STATUS_EMPTY, 0));
        directed.push_back(mk(ise_pkg::FUNC_REMOVE, 9, 3, 1, 0, ise_pkg::STATUS_EMPTY, 0));
        directed.push_back(mk(ise_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 0, 1, 0,
                              ise_pkg::STATUS_EMPTY, 0));
        directed.push_back(mk(ise_pkg::FUNC_NONE, 1, 100, 1, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_ADD, 0, 32'hFFFF_FFFF, 1, 0,
                              ise_pkg::STATUS_DONE, 1));
        directed.push_back(mk(ise_pkg::FUNC_QUERY, 0, 32'hFFFF_FFFF, 1, 1,
                              ise_pkg::STATUS_DONE, 1));
        directed.push_back(mk(ise_pkg::FUNC_REMOVE, 32'h5555_AAAA, 32'hAAAA_5555, 1, 0,
                              ise_pkg::STATUS_DONE, 2));
        directed.push_back(mk(ise_pkg::FUNC_QUERY, 32'h5555_AAAA, 32'h5555_AAAB, 1, 0,
                              ise_pkg::STATUS_DONE, 2));
        directed.push_back(mk(ise_pkg::FUNC_REMOVE, 0, 32'hFFFF_FFFF, 1, 0,
                              ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_ADD, 10, 20, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_ADD, 20, 30, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_ADD, 40, 50, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_ADD, 25, 45, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_QUERY, 10, 50, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_REMOVE, 15, 16, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_QUERY, 14, 16, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_REMOVE, 0, 12, 0, 0, ise_pkg::STATUS_DONE, 0));
        directed.push_back(mk(ise_pkg::FUNC_REMOVE, 48, 60, 0, 0, ise_pkg::STATUS_DONE, 0));

        foreach (directed[k])
        begin
            send_item(directed[k].func, directed[k].lo, directed[k].hi, 1);
            // Rows with typed-in answers must agree with the predictor as well.
            if (directed[k].known && pending_results[$] != directed[k].res)
            begin
                $display("table row %0d disagrees with prediction", k);
                error_count++;
            end
        end
        drain_results();

        // Fill the set to capacity with short disjoint intervals, then poke it.
        for (int k = 0; k < CAP; k++)
            send_item(ise_pkg::FUNC_ADD, 32'h1000_0000 + k * 8,
                      32'h1000_0000 + k * 8 + 3, 1);
        send_item(ise_pkg::FUNC_ADD, 32'hF000_0000, 32'hF000_0010, 1);
        send_item(ise_pkg::FUNC_REMOVE, 32'h1000_0001, 32'h1000_0002, 1);
        send_item(ise_pkg::FUNC_ADD, 32'h1000_0003, 32'h1000_0008, 1);
        send_item(ise_pkg::FUNC_REMOVE, 32'h1000_0001, 32'h1000_0002, 1);

        // Receiver holds off while items keep arriving.
        rx_long_stall = 1'b1;
        for (int k = 0; k < 6; k++)
            send_item(ise_pkg::FUNC_QUERY, 32'h1000_0000 + k * 8,
                      32'h1000_0002 + k * 8, 0);
        rx_long_stall = 1'b0;
        drain_results();
        send_item(ise_pkg::FUNC_REMOVE, 0, 32'hFFFF_FFFF, 1);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS - 60) rx_no_idle = 1'b1;
            r = $urandom_range(0, 99);
            f = ise_pkg::func_t'($urandom_range(0, 2));
            if (r < 80)
            begin
                s = small_coord();
                e = s + $urandom_range(1, 40);
            end
            else if (r < 88)
            begin
                s = $urandom();
                e = $urandom();
            end
            else if (r < 93)
            begin
                s = small_coord();
                e = s - $urandom_range(0, 3);
            end
            else if (r < 96)
            begin
                f = ise_pkg::FUNC_NONE;
                s = $urandom();
                e = $urandom();
            end
            else
            begin
                f = ise_pkg::FUNC_REMOVE;
                s = 0;
                e = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd200;
            end
            if (set_lo.size() > 50 && f == ise_pkg::FUNC_ADD && r < 80)
                f = ise_pkg::FUNC_REMOVE;
            send_item(f, s, e, k < RANDOM_ITEMS - 60);
        end
        drain_results();
        sender_done = 1'b1;
    end

    // Receiver.
    initial
    begin
        int stall;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_long_stall)
            begin
                result.ready <= 1'b0;
                repeat (400) @(posedge clk);
                result.ready <= 1'b1;
                wait (!rx_long_stall);
            end
            else if (!rx_no_idle && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 10);
                result.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    // Result checker.
    initial
    begin
        outcome_t want;
        error_count = 0;
        result_count = 0;
        accepted_count = 0;
        capacity_hits = 0;
        split_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result.valid && result.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("result %0d arrived with nothing expected", result_count);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.covered !== want.covered)
                        report_mismatch("covered", result.covered, want.covered);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.interval_count !== want.interval_count)
                        report_mismatch("interval_count", result.interval_count,
                                        want.interval_count);
                end
                result_count++;
            end
        end
    end

    initial
    begin
        wait (sender_done);
        repeat (300) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            error_count++;
        end
        $display("Covered %0d transactions: %0d capacity rejections, %0d splits.",
                 accepted_count, capacity_hits, split_count);
        if (error_count == 0)
            $display("interval_set_engine_core_test passed");
        else
            $display("interval_set_engine_core_test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("interval_set_engine_core_test failed");
        $finish;
    end

endmodule
